>>> sv/ptu_pkg.sv
package ptu_pkg;

  localparam int NUM_SLOTS     = 64;
  localparam int PRIORITY_BITS = 4;
  localparam int COUNT_BITS    = 16;

  localparam int IDX_W  = $clog2(NUM_SLOTS);
  localparam int SLOT_W = 6;
  localparam int EXT_W  = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;

  localparam int STATE_W  = 2;
  localparam int EPRIO_W  = 4;
  localparam int THR_W    = 16;
  localparam int CFG_PRI_W = 4;
  localparam int CMP_W    = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;
  localparam int PCMP_W   = (PRIORITY_BITS > CFG_PRI_W) ? PRIORITY_BITS : CFG_PRI_W;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_AGING_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM_LENGTH  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BEST_PRIORITY   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_WORST_PRIORITY  = CFG_IDX_W'(3);

  localparam logic [THR_W-1:0]     AGING_RESET   = THR_W'(100);
  localparam logic [THR_W-1:0]     QUANTUM_RESET = THR_W'(10);
  localparam logic [CFG_PRI_W-1:0] BEST_RESET    = CFG_PRI_W'(0);
  localparam logic [CFG_PRI_W-1:0] WORST_RESET   = CFG_PRI_W'(15);

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  localparam logic [STATE_W-1:0] ST_OTHER    = STATE_W'(0);
  localparam logic [STATE_W-1:0] ST_RUNNABLE = STATE_W'(1);
  localparam logic [STATE_W-1:0] ST_RUNNING  = STATE_W'(2);

  localparam logic [PRIORITY_BITS-1:0] PRIO_MAX = {PRIORITY_BITS{1'b1}};

  typedef struct packed {
    logic [STATE_W-1:0]       st;
    logic [PRIORITY_BITS-1:0] prio;
    logic [COUNT_BITS-1:0]    wait_cnt;
    logic [COUNT_BITS-1:0]    run_cnt;
  } entry_t;

endpackage

>>> sv/ptu_if.sv
interface ptu_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic [ptu_pkg::SLOT_W-1:0]          slot;
  logic                                running_valid;
  logic [ptu_pkg::STATE_W-1:0]         entry_state;
  logic [ptu_pkg::EPRIO_W-1:0]         entry_priority;

  modport source (output valid, mode, slot, running_valid, entry_state, entry_priority,
                  input ready);
  modport sink   (input valid, mode, slot, running_valid, entry_state, entry_priority,
                  output ready);
endinterface

interface ptu_out_if;
  logic                         valid;
  logic                         ready;
  logic                         yield_request;
  logic [ptu_pkg::EPRIO_W-1:0]  running_priority;

  modport source (output valid, yield_request, running_priority, input ready);
  modport sink   (input valid, yield_request, running_priority, output ready);
endinterface

interface ptu_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ptu_pkg::CFG_IDX_W-1:0]      index;
  logic [ptu_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/ptu_ram.sv
module ptu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/priority_aging_tick_update_top.sv
// channel | dir | handshake     | payload
// in_i    | in  | valid / ready | mode, slot, running_valid, entry_state, entry_priority
// out_o   | out | valid / ready | yield_request, running_priority
// cfg_i   | in  | valid / ready | index, data (ready always high)
//
// a tick walks all NUM_SLOTS slot entries between accept and result: one
// slot entry per cycle is read, updated by the single counter/priority unit and
// written back through the one-read one-write slot ram
// a load writes the addressed slot entry, if in range; a new item is taken
// as soon as the result is parked in the output register, even while out_o is stalled
// after reset all slots read as zero through per-slot valid bits, no clearing pass
module priority_aging_tick_update_top (
  input  logic  clk_i,
  input  logic  rst_ni,
  ptu_in_if.sink    in_i,
  ptu_out_if.source out_o,
  ptu_cfg_if.sink   cfg_i
);
  import ptu_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOAD  = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;
  localparam int TICK_CYCLES = NUM_SLOTS + 2;

  logic [1:0] state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] pidx_q, pidx_d;
  logic pv_q, pv_d;
  logic done_q, done_d;
  logic [NUM_SLOTS-1:0] valid_q;

  logic mode_q, rvalid_q;
  logic [EXT_W-1:0] slot_q;
  logic [STATE_W-1:0] est_q;
  logic [EPRIO_W-1:0] epri_q;

  logic res_yield_q, res_yield_d;
  logic [EPRIO_W-1:0] res_prio_q, res_prio_d;

  logic out_valid_q;
  logic out_yield_q;
  logic [EPRIO_W-1:0] out_prio_q;

  logic [THR_W-1:0] aging_q, quantum_q;
  logic [CFG_PRI_W-1:0] best_q, worst_q;

  logic ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t ram_wdata, ram_rdata;

  logic in_fire, in_range;
  entry_t ent, ent_new;
  logic is_run, is_cur, hit, cur_match;
  logic [COUNT_BITS-1:0] cnt_sel, cnt_inc;
  logic [THR_W-1:0] thr_sel;
  logic [PCMP_W-1:0] p_ext;

  assign in_fire = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE) && !done_q;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid = out_valid_q;
  assign out_o.yield_request = out_yield_q;
  assign out_o.running_priority = out_prio_q;

  assign in_range = slot_q < EXT_W'(NUM_SLOTS);

  ptu_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(NUM_SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign ram_raddr = idx_q;

  // shared counter and priority unit, one slot entry per cycle
  always_comb begin
    ent       = valid_q[pidx_q] ? ram_rdata : '0;
    is_run    = (ent.st == ST_RUNNABLE);
    cur_match = (slot_q == EXT_W'(pidx_q));
    is_cur    = cur_match && rvalid_q && (ent.st == ST_RUNNING);
    cnt_sel   = is_run ? ent.wait_cnt : ent.run_cnt;
    thr_sel   = is_run ? aging_q : quantum_q;
    cnt_inc   = cnt_sel + COUNT_BITS'(1);
    hit       = CMP_W'(cnt_inc) >= CMP_W'(thr_sel);
    p_ext     = PCMP_W'(ent.prio);
    ent_new   = ent;
    if (is_run) begin
      ent_new.wait_cnt = hit ? '0 : cnt_inc;
      if (hit && (p_ext > PCMP_W'(best_q))) begin
        ent_new.prio = ent.prio - PRIORITY_BITS'(1);
      end
    end else if (is_cur) begin
      ent_new.run_cnt = hit ? '0 : cnt_inc;
      if (hit && (p_ext < PCMP_W'(worst_q)) && (ent.prio != PRIO_MAX)) begin
        ent_new.prio = ent.prio + PRIORITY_BITS'(1);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pidx_d      = pidx_q;
    pv_d        = 1'b0;
    done_d      = done_q;
    res_yield_d = res_yield_q;
    res_prio_d  = res_prio_q;
    ram_we      = 1'b0;
    ram_waddr   = pidx_q;
    ram_wdata   = ent_new;

    if (pv_q) begin
      ram_we = 1'b1;
      if (cur_match) begin
        res_prio_d  = EPRIO_W'(ent_new.prio);
        res_yield_d = is_cur && hit;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_yield_d = 1'b0;
          res_prio_d  = '0;
          idx_d       = '0;
          state_d     = (in_i.mode == MODE_LOAD) ? S_LOAD : S_WALK;
        end
      end
      S_LOAD: begin
        if (in_range) begin
          ram_we         = 1'b1;
          ram_waddr      = slot_q[IDX_W-1:0];
          ram_wdata.st   = est_q;
          ram_wdata.prio = PRIORITY_BITS'(epri_q);
          ram_wdata.wait_cnt = '0;
          ram_wdata.run_cnt  = '0;
          res_prio_d     = EPRIO_W'(PRIORITY_BITS'(epri_q));
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_WALK: begin
        pv_d   = 1'b1;
        pidx_d = idx_q;
        idx_d  = idx_q + IDX_W'(1);
        if (idx_q == IDX_W'(NUM_SLOTS - 1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (done_q && (!out_valid_q || out_o.ready)) begin
      done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      pidx_q      <= '0;
      pv_q        <= 1'b0;
      done_q      <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      aging_q     <= AGING_RESET;
      quantum_q   <= QUANTUM_RESET;
      best_q      <= BEST_RESET;
      worst_q     <= WORST_RESET;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pidx_q  <= pidx_d;
      pv_q    <= pv_d;
      done_q  <= done_d;
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (done_q && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_AGING_THRESHOLD: aging_q   <= THR_W'(cfg_i.data);
          REG_QUANTUM_LENGTH:  quantum_q <= THR_W'(cfg_i.data);
          REG_BEST_PRIORITY:   best_q    <= cfg_i.data[CFG_PRI_W-1:0];
          REG_WORST_PRIORITY:  worst_q   <= cfg_i.data[CFG_PRI_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_yield_q <= res_yield_d;
    res_prio_q  <= res_prio_d;
    if (in_fire) begin
      mode_q   <= in_i.mode;
      slot_q   <= EXT_W'(in_i.slot);
      rvalid_q <= in_i.running_valid;
      est_q    <= in_i.entry_state;
      epri_q   <= in_i.entry_priority;
    end
    if (done_q && (!out_valid_q || out_o.ready)) begin
      out_yield_q <= res_yield_q;
      out_prio_q  <= res_prio_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_tick_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.mode == MODE_TICK) |-> ##TICK_CYCLES (state_q == S_IDLE && done_q))
    else $error("tick result not ready after slot walk");

  a_load_no_yield: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && mode_q == MODE_LOAD) |-> !res_yield_q)
    else $error("yield raised by a load item");

  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (pv_q || state_q == S_LOAD))
    else $error("slot ram written outside walk or load");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pv_q && state_q == S_WALK) |-> (ram_raddr != pidx_q))
    else $error("slot ram read and write at same entry");
`endif

endmodule
